// ----- rtl/vrs_pkg.sv -----
// Shared types, widths and state codes for the voxel ray sampler.
`timescale 1ns / 1ps
package vrs_pkg;

  localparam int CRD_W  = 24;  // Q12.12 coordinate
  localparam int REL_W  = 25;  // start - origin, end - start
  localparam int RES_W  = 23;  // resolution
  localparam int SZ_W   = 11;  // grid size register
  localparam int CELL_W = 10;  // emitted cell index
  localparam int QW     = 28;  // signed dividend / quotient
  localparam int DVW    = 25;  // divisor / remainder
  localparam int STW    = 26;  // step count
  localparam int CFG_IDX_W = 3;

  localparam int MAX_STEPS_DEF = 64;
  localparam int GRID_MAX_DEF  = 1024;
  localparam logic [RES_W-1:0] RES_RST  = RES_W'(409);
  localparam logic [SZ_W-1:0]  SIZE_RST = SZ_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_RESOLUTION = 3'd3,
    REG_SIZE_X     = 3'd4,
    REG_SIZE_Y     = 3'd5,
    REG_SIZE_Z     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][REL_W-1:0] rel;
    logic [2:0][REL_W-1:0] d;
    logic [CRD_W-1:0]      maxd;
  } ray_t;

  typedef struct packed {
    logic [2:0][CELL_W-1:0] idx;
    logic                   cell_valid;
    logic                   truncated;
    logic                   last;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_STEPS,
    B_STEPS_W,
    B_DENOM,
    B_REL,
    B_REL_W,
    B_REM,
    B_DD,
    B_DD_W,
    B_WALK,
    B_DONE
  } back_state_t;

endpackage

// ----- rtl/vrs_div.sv -----
// Multi-cycle floor divider: signed dividend by positive divisor, one bit per cycle.
`timescale 1ns / 1ps
module vrs_div import vrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [QW-1:0]  dividend,
  input  logic [DVW-1:0]        divisor,
  output logic                  done,
  output logic signed [QW-1:0]  quot,
  output logic [DVW-1:0]        rem
);
  localparam int MAGW = QW - 1;
  localparam int CNTW = $clog2(MAGW + 1);

  logic              run_r, fix_r, done_r, neg_r;
  logic [CNTW-1:0]   cnt_r;
  logic [MAGW-1:0]   mag_r, mag_nxt;
  logic [DVW-1:0]    part_r, part_nxt, dvs_r;
  logic [DVW:0]      trial, diff;
  logic              ge;
  logic [QW-1:0]     absval;
  logic signed [QW-1:0] quot_r;
  logic [DVW-1:0]    rem_r;

  assign absval   = dividend[QW-1] ? (-dividend) : dividend;
  assign trial    = {part_r, mag_r[MAGW-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign part_nxt = ge ? diff[DVW-1:0] : trial[DVW-1:0];
  assign mag_nxt  = {mag_r[MAGW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(MAGW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r <= 1'b0;
          fix_r <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[QW-1];
      mag_r  <= absval[MAGW-1:0];
      part_r <= '0;
      dvs_r  <= divisor;
    end else if (run_r) begin
      mag_r  <= mag_nxt;
      part_r <= part_nxt;
    end else if (fix_r) begin
      if (neg_r && (part_r != '0)) begin
        quot_r <= -$signed({1'b0, mag_r}) - QW'(1);
        rem_r  <= dvs_r - part_r;
      end else if (neg_r) begin
        quot_r <= -$signed({1'b0, mag_r});
        rem_r  <= '0;
      end else begin
        quot_r <= $signed({1'b0, mag_r});
        rem_r  <= part_r;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/vrs_queue.sv -----
// Two-entry ray queue between the front and back parts.
`timescale 1ns / 1ps
module vrs_queue import vrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ray_t push_data,
  input  logic pop,
  output ray_t head,
  output logic empty,
  output logic full
);
  ray_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

// ----- rtl/vrs_front.sv -----
// Front part: takes a segment, forms start-origin, direction and its largest component.
`timescale 1ns / 1ps
module vrs_front import vrs_pkg::*; (
  input  logic                    start,
  input  logic                    q_full,
  input  logic [2:0][CRD_W-1:0]   seg_start,
  input  logic [2:0][CRD_W-1:0]   seg_end,
  input  logic [2:0][CRD_W-1:0]   origin,
  output logic                    busy,
  output logic                    push,
  output ray_t                    ray
);
  logic signed [REL_W-1:0] s_ext [3];
  logic signed [REL_W-1:0] e_ext [3];
  logic signed [REL_W-1:0] o_ext [3];
  logic signed [REL_W-1:0] d    [3];
  logic [CRD_W-1:0]        mag  [3];
  logic [CRD_W-1:0]        m01;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_ext[i] = REL_W'($signed(seg_start[i]));
      e_ext[i] = REL_W'($signed(seg_end[i]));
      o_ext[i] = REL_W'($signed(origin[i]));
      d[i]     = e_ext[i] - s_ext[i];
      mag[i]   = d[i][REL_W-1] ? CRD_W'(-d[i]) : CRD_W'(d[i]);
      ray.rel[i] = s_ext[i] - o_ext[i];
      ray.d[i]   = d[i];
    end
    m01      = (mag[1] > mag[0]) ? mag[1] : mag[0];
    ray.maxd = (mag[2] > m01) ? mag[2] : m01;
  end

  assign busy = q_full;
  assign push = start && !q_full;

endmodule

// ----- rtl/vrs_back.sv -----
// Back part: step count and per-axis setup by division, then the incremental cell walk.
`timescale 1ns / 1ps
module vrs_back import vrs_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int GRID_MAX  = GRID_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ray_t                  head,
  input  logic                  q_empty,
  output logic                  pop,
  input  logic [RES_W-1:0]      resolution,
  input  logic [2:0][SZ_W-1:0]  size,
  output logic                  out_strobe,
  output result_t               out_res
);
  localparam int LIM_W = $clog2(MAX_STEPS + 1);

  back_state_t state_r, state_nxt;

  logic [STW-1:0]   steps_r;
  logic             trunc_r;
  logic [LIM_W-1:0] limit_r, n_r;
  logic [DVW-1:0]   denom_r;
  logic [1:0]       axis_r;
  logic [RES_W-1:0] rm_r;
  logic signed [QW-1:0] c_r  [3];
  logic signed [QW-1:0] qd_r [3];
  logic [DVW-1:0]       r_r  [3];
  logic [DVW-1:0]       rd_r [3];
  logic [2:0][SZ_W-1:0] pend_r;
  logic                 have_pend_r;
  logic                 out_strobe_r;
  result_t              out_res_r;

  logic [RES_W-1:0]     res_eff;
  logic [2:0][SZ_W-1:0] size_eff;
  logic                 div_start, div_done;
  logic signed [QW-1:0] div_dividend, div_quot;
  logic [DVW-1:0]       div_divisor, div_rem;
  logic [RES_W-1:0]     mul_b;
  logic [STW+RES_W-1:0] prod;
  logic [STW-1:0]       steps_q;

  logic [DVW:0]         sum  [3];
  logic                 wrap [3];
  logic [DVW-1:0]       nr   [3];
  logic signed [QW-1:0] nc   [3];
  logic                 outside, same, walk_end;
  logic signed [QW-1:0] rel_sel, d_sel;

  assign res_eff = (resolution == '0) ? RES_W'(1) : resolution;
  assign steps_q = div_quot[STW-1:0];
  assign rel_sel = QW'($signed(head.rel[axis_r]));
  assign d_sel   = QW'($signed(head.d[axis_r]));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      size_eff[i] = (32'(size[i]) > 32'(GRID_MAX)) ? SZ_W'(GRID_MAX) : size[i];
    end
  end

  vrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign prod = steps_r * mul_b;

  // walk datapath
  always_comb begin
    outside = 1'b0;
    same    = have_pend_r;
    for (int i = 0; i < 3; i++) begin
      sum[i]  = {1'b0, r_r[i]} + {1'b0, rd_r[i]};
      wrap[i] = sum[i] >= {1'b0, denom_r};
      nr[i]   = wrap[i] ? DVW'(sum[i] - {1'b0, denom_r}) : sum[i][DVW-1:0];
      nc[i]   = c_r[i] + qd_r[i] + QW'(wrap[i]);
      if (nc[i][QW-1] || ($unsigned(nc[i]) >= QW'(size_eff[i]))) outside = 1'b1;
      if (nc[i][SZ_W-1:0] != pend_r[i]) same = 1'b0;
    end
    walk_end = (n_r >= limit_r) || outside;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:    if (!q_empty) state_nxt = B_STEPS;
      B_STEPS:   state_nxt = B_STEPS_W;
      B_STEPS_W: if (div_done) state_nxt = (steps_q < STW'(2)) ? B_DONE : B_DENOM;
      B_DENOM:   state_nxt = B_REL;
      B_REL:     state_nxt = B_REL_W;
      B_REL_W:   if (div_done) state_nxt = B_REM;
      B_REM:     state_nxt = B_DD;
      B_DD:      state_nxt = B_DD_W;
      B_DD_W:    if (div_done) state_nxt = (axis_r == 2'd2) ? B_WALK : B_REL;
      B_WALK:    if (walk_end) state_nxt = B_DONE;
      B_DONE:    state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = rel_sel;
    div_divisor  = DVW'(res_eff);
    mul_b        = rm_r;
    pop          = 1'b0;
    unique case (state_r)
      B_STEPS: begin
        div_start    = 1'b1;
        div_dividend = QW'({head.maxd, 2'b00}) + QW'(head.maxd);
        div_divisor  = {res_eff, 2'b00};
      end
      B_REL:   div_start = 1'b1;
      B_DD: begin
        div_start    = 1'b1;
        div_dividend = d_sel;
        div_divisor  = denom_r;
      end
      B_DENOM: mul_b = res_eff;
      B_DONE:  pop = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_strobe_r <= 1'b0;
      have_pend_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      unique case (state_r)
        B_STEPS: have_pend_r <= 1'b0;
        B_WALK: begin
          if (!walk_end && !same) begin
            have_pend_r <= 1'b1;
            if (have_pend_r) out_strobe_r <= 1'b1;
          end
        end
        B_DONE: out_strobe_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_STEPS_W: begin
        if (div_done) begin
          steps_r <= steps_q;
          trunc_r <= steps_q > STW'(MAX_STEPS);
          limit_r <= (steps_q > STW'(MAX_STEPS)) ? LIM_W'(MAX_STEPS) : steps_q[LIM_W-1:0];
        end
      end
      B_DENOM: begin
        denom_r <= prod[DVW-1:0];
        axis_r  <= 2'd0;
      end
      B_REL_W: begin
        if (div_done) begin
          c_r[axis_r] <= div_quot;
          rm_r        <= div_rem[RES_W-1:0];
        end
      end
      B_REM: r_r[axis_r] <= prod[DVW-1:0];
      B_DD_W: begin
        if (div_done) begin
          qd_r[axis_r] <= div_quot;
          rd_r[axis_r] <= div_rem;
          axis_r       <= axis_r + 2'd1;
          n_r          <= LIM_W'(1);
        end
      end
      B_WALK: begin
        if (!walk_end) begin
          n_r <= n_r + LIM_W'(1);
          for (int i = 0; i < 3; i++) begin
            c_r[i] <= nc[i];
            r_r[i] <= nr[i];
          end
          if (!same) begin
            for (int i = 0; i < 3; i++) begin
              pend_r[i] <= nc[i][SZ_W-1:0];
              out_res_r.idx[i] <= pend_r[i][CELL_W-1:0];
            end
            out_res_r.cell_valid <= 1'b1;
            out_res_r.truncated  <= trunc_r;
            out_res_r.last       <= 1'b0;
          end
        end
      end
      B_DONE: begin
        for (int i = 0; i < 3; i++) begin
          out_res_r.idx[i] <= have_pend_r ? pend_r[i][CELL_W-1:0] : CELL_W'(0);
        end
        out_res_r.cell_valid <= have_pend_r;
        out_res_r.truncated  <= trunc_r;
        out_res_r.last       <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

`ifndef SYNTHESIS
  a_last_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_res_r.last) |-> ($past(state_r) == B_DONE))
    else $error("final result not from done state");
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_res_r.cell_valid) |-> out_res_r.last)
    else $error("empty result without last");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (n_r <= limit_r))
    else $error("sample index beyond limit");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/voxel_ray_sampler_unit.sv -----
// Top level of the voxel ray sampler: config registers, front, queue and back.
//
//  channel | ports                                     | transfer
//  input   | start, busy, in_start_*, in_end_*         | start && !busy
//  result  | out_strobe, out_cell_*, out_*             | out_strobe, one cycle
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Per ray: seven serial divisions, each with its setup (27 quotient bits, fix-up,
// done), then the walk over the in-grid samples (at most MAX_STEPS-1). Rays on
// short segments (fewer than two steps) need only the first division.
// Two rays can wait in the queue; busy is high while it is full.
// Synchronous active-low reset; the receiver cannot stall results.
`timescale 1ns / 1ps
module voxel_ray_sampler_unit import vrs_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int GRID_MAX  = GRID_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CRD_W-1:0]     in_start_x,
  input  logic [CRD_W-1:0]     in_start_y,
  input  logic [CRD_W-1:0]     in_start_z,
  input  logic [CRD_W-1:0]     in_end_x,
  input  logic [CRD_W-1:0]     in_end_y,
  input  logic [CRD_W-1:0]     in_end_z,
  output logic                 out_strobe,
  output logic [CELL_W-1:0]    out_cell_x,
  output logic [CELL_W-1:0]    out_cell_y,
  output logic [CELL_W-1:0]    out_cell_z,
  output logic                 out_cell_valid,
  output logic                 out_truncated,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRD_W-1:0]     cfg_data
);
  logic [2:0][CRD_W-1:0] origin_r;
  logic [RES_W-1:0]      res_r;
  logic [2:0][SZ_W-1:0]  size_r;

  ray_t    ray, head;
  logic    push, pop, q_empty, q_full;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      res_r    <= RES_RST;
      size_r   <= {3{SIZE_RST}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:   origin_r[0] <= cfg_data;
        REG_ORIGIN_Y:   origin_r[1] <= cfg_data;
        REG_ORIGIN_Z:   origin_r[2] <= cfg_data;
        REG_RESOLUTION: res_r       <= cfg_data[RES_W-1:0];
        REG_SIZE_X:     size_r[0]   <= cfg_data[SZ_W-1:0];
        REG_SIZE_Y:     size_r[1]   <= cfg_data[SZ_W-1:0];
        REG_SIZE_Z:     size_r[2]   <= cfg_data[SZ_W-1:0];
        default: ;
      endcase
    end
  end

  vrs_front u_front (
    .start     (start),
    .q_full    (q_full),
    .seg_start ({in_start_z, in_start_y, in_start_x}),
    .seg_end   ({in_end_z, in_end_y, in_end_x}),
    .origin    (origin_r),
    .busy      (busy),
    .push      (push),
    .ray       (ray)
  );

  vrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (ray),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  vrs_back #(
    .MAX_STEPS (MAX_STEPS),
    .GRID_MAX  (GRID_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .resolution (res_r),
    .size       (size_r),
    .out_strobe (out_strobe),
    .out_res    (res)
  );

  assign out_cell_x     = res.idx[0];
  assign out_cell_y     = res.idx[1];
  assign out_cell_z     = res.idx[2];
  assign out_cell_valid = res.cell_valid;
  assign out_truncated  = res.truncated;
  assign out_last       = res.last;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the voxel ray sampler: directed table, random rays, live predictor.
`timescale 1ns / 1ps
module testbench import vrs_pkg::*; ();

  localparam int MAX_ST = MAX_STEPS_DEF;
  localparam int GRID   = GRID_MAX_DEF;
  localparam int WDOG   = 20000;

  typedef struct packed {
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [CELL_W-1:0] cz;
    logic              cv;
    logic              tr;
    logic              lst;
  } cell_res_t;

  typedef struct {
    logic [CRD_W-1:0] s[3];
    logic [CRD_W-1:0] e[3];
    bit               fixed;
    cell_res_t        want;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CRD_W-1:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic [CRD_W-1:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_strobe;
  logic [CELL_W-1:0] out_cell_x, out_cell_y, out_cell_z;
  logic out_cell_valid, out_truncated, out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CRD_W-1:0] cfg_data = '0;

  voxel_ray_sampler_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .out_strobe(out_strobe), .out_cell_x(out_cell_x), .out_cell_y(out_cell_y),
    .out_cell_z(out_cell_z), .out_cell_valid(out_cell_valid),
    .out_truncated(out_truncated), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  logic signed [CRD_W-1:0] grid_org[3];
  logic [RES_W-1:0] cell_edge;
  logic [SZ_W-1:0] grid_dim[3];

  cell_res_t pending_cells[$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void add_expect(cell_res_t x);
    pending_cells = {pending_cells, x};
  endfunction

  function automatic void predict_cells(ray_row_t r);
    longint rel[3], dd[3], lim_sz[3], c[3], prv[3];
    longint res, maxd, steps, lim, den, ad;
    bit tr, have, outside;
    int cnt;
    cell_res_t x;
    res = cell_edge;
    if (res == 0) res = 1;
    maxd = 0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = longint'($signed(r.s[i])) - longint'(grid_org[i]);
      dd[i] = longint'($signed(r.e[i])) - longint'($signed(r.s[i]));
      ad = dd[i] < 0 ? -dd[i] : dd[i];
      if (ad > maxd) maxd = ad;
      lim_sz[i] = grid_dim[i] > GRID ? GRID : grid_dim[i];
    end
    steps = (5 * maxd) / (4 * res);
    lim = steps;
    tr = 0;
    if (steps > MAX_ST) begin
      lim = MAX_ST;
      tr = 1;
    end
    den = steps * res;
    cnt = 0;
    have = 0;
    for (longint n = 1; n < lim; n++) begin
      outside = 0;
      for (int i = 0; i < 3; i++) begin
        c[i] = fdiv(rel[i] * steps + dd[i] * n, den);
        if (c[i] < 0 || c[i] >= lim_sz[i]) outside = 1;
      end
      if (outside) break;
      if (!have || c[0] != prv[0] || c[1] != prv[1] || c[2] != prv[2]) begin
        x.cx = c[0][CELL_W-1:0];
        x.cy = c[1][CELL_W-1:0];
        x.cz = c[2][CELL_W-1:0];
        x.cv = 1;
        x.tr = tr;
        x.lst = 0;
        add_expect(x);
        cnt++;
      end
      prv = c;
      have = 1;
    end
    if (cnt == 0) begin
      x = '{cx: '0, cy: '0, cz: '0, cv: 1'b0, tr: tr, lst: 1'b1};
      add_expect(x);
    end else begin
      pending_cells[$].lst = 1;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    cell_res_t got, exp_r;
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_strobe) begin
      got = '{out_cell_x, out_cell_y, out_cell_z, out_cell_valid, out_truncated, out_last};
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = pending_cells.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x%0d y%0d z%0d v%b t%b l%b got x%0d y%0d z%0d v%b t%b l%b",
                     exp_r.cx, exp_r.cy, exp_r.cz, exp_r.cv, exp_r.tr, exp_r.lst,
                     got.cx, got.cy, got.cz, got.cv, got.tr, got.lst);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WDOG) begin
      $display("voxel_ray_sampler_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CRD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X: grid_org[0] = val;
      REG_ORIGIN_Y: grid_org[1] = val;
      REG_ORIGIN_Z: grid_org[2] = val;
      REG_RESOLUTION: cell_edge = val[RES_W-1:0];
      REG_SIZE_X: grid_dim[0] = val[SZ_W-1:0];
      REG_SIZE_Y: grid_dim[1] = val[SZ_W-1:0];
      default: grid_dim[2] = val[SZ_W-1:0];
    endcase
  endtask

  task automatic set_grid(int ox, int oy, int oz, int res, int sx, int sy, int sz);
    write_reg(REG_ORIGIN_X, CRD_W'(ox));
    write_reg(REG_ORIGIN_Y, CRD_W'(oy));
    write_reg(REG_ORIGIN_Z, CRD_W'(oz));
    write_reg(REG_RESOLUTION, CRD_W'(res));
    write_reg(REG_SIZE_X, CRD_W'(sx));
    write_reg(REG_SIZE_Y, CRD_W'(sy));
    write_reg(REG_SIZE_Z, CRD_W'(sz));
  endtask

  task automatic drain();
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic send_ray(ray_row_t r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    start <= 1'b1;
    in_start_x <= r.s[0]; in_start_y <= r.s[1]; in_start_z <= r.s[2];
    in_end_x <= r.e[0]; in_end_y <= r.e[1]; in_end_z <= r.e[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.fixed) add_expect(r.want);
    else predict_cells(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic ray_row_t mk(int sx, int sy, int sz, int ex, int ey, int ez);
    ray_row_t r;
    r.s = '{sx[CRD_W-1:0], sy[CRD_W-1:0], sz[CRD_W-1:0]};
    r.e = '{ex[CRD_W-1:0], ey[CRD_W-1:0], ez[CRD_W-1:0]};
    r.fixed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic ray_row_t mk_empty(int sx, int sy, int sz, int ex, int ey, int ez,
                                        bit tr);
    ray_row_t r;
    r = mk(sx, sy, sz, ex, ey, ez);
    r.fixed = 1;
    r.want = '{cx: '0, cy: '0, cz: '0, cv: 1'b0, tr: tr, lst: 1'b1};
    return r;
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // mostly in-grid rays with small sizes; some full-range noise
  function automatic ray_row_t rnd_ray(int span);
    ray_row_t r;
    int base[3];
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 3; i++) begin
        r.s[i] = CRD_W'($urandom);
        r.e[i] = CRD_W'($urandom);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        base[i] = int'(grid_org[i]) + $urandom_range(0, span);
        r.s[i] = CRD_W'(base[i]);
        r.e[i] = CRD_W'(base[i] + rnd_coord(span));
      end
    end
    r.fixed = 0;
    r.want = '0;
    return r;
  endfunction

  initial begin
    ray_row_t dir_rows[$];
    int span;
    grid_org = '{0, 0, 0};
    cell_edge = RES_RST;
    grid_dim = '{SIZE_RST, SIZE_RST, SIZE_RST};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration
    dir_rows = {
      mk_empty(0, 0, 0, 0, 0, 0, 1'b0),
      mk_empty(100, 100, 100, 300, 100, 100, 1'b0),
      mk(0, 0, 0, 4090, 2000, 1000),
      mk(4090, 4090, 4090, 0, 0, 0),
      mk(1000, 1000, 1000, 30000, 25000, 1000),
      mk(0, 0, 0, 8388607, 8388607, 8388607),
      mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607),
      mk_empty(-5000, 0, 0, -1000, 0, 0, 1'b0),
      mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608),
      mk(200, 50000, 200, 200, -2000, 200),
      mk(100, 100, 100, 26300, 100, 100),
      mk(100, 100, 100, 26400, 100, 100)
    };
    foreach (dir_rows[i]) send_ray(dir_rows[i]);
    drain();

    // extremes: zero resolution, tiny grid, negative origin
    set_grid(24'h800000, 24'h7FFFFF, 24'hFFF000, 24'd0, 11'd0, 11'd1, 11'd2047);
    dir_rows = {
      mk(-8388608, 8388607, -4096, -8388600, 8388607, -4090),
      mk_empty(0, 0, 0, 10, 0, 0, 1'b0)
    };
    foreach (dir_rows[i]) send_ray(dir_rows[i]);
    drain();
    set_grid(24'hFFFC00, 24'hFFF800, 24'h000400, 24'h7FFFFF, 11'd1024, 11'd1024, 11'd1024);
    send_ray(mk(0, 0, 0, 8388607, -8388608, 8388607));
    send_ray(mk(-8388608, 0, 0, 8388607, 0, 0));
    drain();

    // random phases over several grids
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_grid(0, 0, 0, 409, 1024, 1024, 1024);
        1: set_grid(24'hFFE000, 24'h001000, 0, 64, 40, 40, 40);
        2: set_grid(0, 0, 0, 1, 1024, 1024, 1024);
        3: set_grid($urandom, $urandom, $urandom, $urandom_range(1, 2000),
                    $urandom_range(1, 1024), $urandom_range(1, 1024),
                    $urandom_range(1, 1024));
        4: set_grid(24'h7FF000, 24'h800000, 24'h000123, 4096, 3, 2047, 8);
        5: set_grid(0, 0, 0, 24'h7FFFFF, 1, 1, 1);
        default: set_grid($urandom, $urandom, $urandom, $urandom_range(50, 900),
                          1024, 1024, 1024);
      endcase
      span = int'(cell_edge == 0 ? 1 : cell_edge) * ($urandom_range(0, 1) ? 80 : 20);
      if (span > 4000000) span = 4000000;
      for (int k = 0; k < 38; k++) send_ray(rnd_ray(span));
      drain();
    end

    if (mismatches == 0 && pending_cells.size() == 0)
      $display("voxel_ray_sampler_unit verification clean");
    else
      $display("voxel_ray_sampler_unit verification failed");
    $finish;
  end
endmodule
